/* rtl/lcds_pkg.sv */
// package for the character lcd nibble sequencer
// request codes, queued operation type, sequencer states, timing constants
// no dependencies
`timescale 1ns / 1ps

package lcds_pkg;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_CURSOR = 2'd2,
    REQ_WRITE  = 2'd3
  } req_code_t;

  // kind of work handed from front to back
  typedef enum logic [1:0] {
    KIND_INIT = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_CHAR = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_t;

  localparam logic [1:0] ROW_FIRST  = 2'd1;
  localparam logic [1:0] ROW_SECOND = 2'd2;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] ADDR_ROW1 = 8'h80;
  localparam logic [7:0] ADDR_ROW2 = 8'hC0;
  localparam logic [3:0] NIB_MASK  = 4'hF;

  localparam logic [3:0] INIT_WAIT_MS = 4'd15;
  localparam logic [3:0] CHAR_WAIT_MS = 4'd8;
  localparam logic [3:0] PULSE_MS     = 4'd5;
  localparam logic [3:0] TAIL_MS      = 4'd3;

  // index of the final pin state of each kind
  localparam logic [4:0] INIT_LAST_STEP = 5'd20;
  localparam logic [4:0] CMD_LAST_STEP  = 5'd3;
  localparam logic [4:0] CHAR_LAST_STEP = 5'd4;

  localparam int QUEUE_DEPTH = 4;

  // power-up command bytes
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h0C;
      3'd4:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/lcds_front.sv */
// front end: classifies requests into queued operations
// depends on lcds_pkg
`timescale 1ns / 1ps

module lcds_front (
  input  logic            push,
  input  logic [1:0]      req_type,
  input  logic [1:0]      row,
  input  logic [5:0]      column,
  input  logic [7:0]      char_code,
  input  logic            q_full,
  output logic            q_push,
  output lcds_pkg::op_t   q_data
);
  import lcds_pkg::*;

  logic       keep;
  logic [7:0] col_off;

  // column counts from 1, wraps modulo 256
  assign col_off = {2'b00, column} - 8'd1;

  always_comb begin
    keep        = 1'b1;
    q_data.kind = KIND_CMD;
    q_data.data = CMD_CLEAR;
    case (req_code_t'(req_type))
      REQ_INIT: begin
        q_data.kind = KIND_INIT;
        q_data.data = 8'h00;
      end
      REQ_CLEAR: begin
        q_data.kind = KIND_CMD;
        q_data.data = CMD_CLEAR;
      end
      REQ_CURSOR: begin
        q_data.kind = KIND_CMD;
        if (row == ROW_FIRST) begin
          q_data.data = ADDR_ROW1 + col_off;
        end else if (row == ROW_SECOND) begin
          q_data.data = ADDR_ROW2 + col_off;
        end else begin
          keep = 1'b0;
        end
      end
      REQ_WRITE: begin
        q_data.kind = KIND_CHAR;
        q_data.data = char_code;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // invalid cursor rows are accepted and dropped
  assign q_push = push && !q_full && keep;

endmodule

/* rtl/lcds_queue.sv */
// small fifo of classified operations between front and back
// depends on lcds_pkg
`timescale 1ns / 1ps

module lcds_queue #(
  parameter int DEPTH = lcds_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcds_pkg::op_t   din,
  output logic            full,
  input  logic            pop,
  output lcds_pkg::op_t   dout,
  output logic            empty
);
  import lcds_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/lcds_back.sv */
// back end: expands queued operations into timed pin states
// depends on lcds_pkg
`timescale 1ns / 1ps

module lcds_back (
  input  logic            clk,
  input  logic            rst,
  input  lcds_pkg::op_t   q_head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic            reg_select,
  output logic            read_write,
  output logic            enable,
  output logic [3:0]      nibble,
  output logic [3:0]      hold_ms,
  output logic            last
);
  import lcds_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  op_t        cur;
  logic [4:0] step;
  logic       out_valid;
  logic       prev_reg_select;
  logic [3:0] prev_nibble;

  op_t        act;
  logic [4:0] s;
  logic       busy;
  logic       advance;
  logic       go;
  logic       has_wait;
  logic [4:0] rel;
  logic [7:0] byte_v;
  logic [4:0] last_step;
  logic       is_last;
  logic       pin_rs;
  logic       pin_en;
  logic [3:0] pin_nib;
  logic [3:0] pin_hold;
  logic       nib_done;

  assign busy    = (state == SEQ_RUN);
  assign act     = busy ? cur : q_head;
  assign s       = busy ? step : 5'd0;
  assign advance = !out_valid || pop;
  assign go      = advance && (busy || !q_empty);
  assign q_pop   = go && !busy;

  assign has_wait = (act.kind != KIND_CMD);
  assign rel      = s - {4'b0000, has_wait};
  assign byte_v   = (act.kind == KIND_INIT) ? init_cmd(rel[4:2]) : act.data;

  always_comb begin
    case (act.kind)
      KIND_INIT: last_step = INIT_LAST_STEP;
      KIND_CHAR: last_step = CHAR_LAST_STEP;
      default:   last_step = CMD_LAST_STEP;
    endcase
  end

  assign is_last = (s == last_step);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (go && !is_last) begin
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (go && is_last) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // pin state for the current step
  always_comb begin
    pin_rs   = (act.kind == KIND_CHAR);
    pin_en   = 1'b0;
    pin_nib  = byte_v[3:0];
    pin_hold = TAIL_MS;
    nib_done = 1'b0;
    if (has_wait && (s == 5'd0)) begin
      pin_rs   = prev_reg_select;
      pin_nib  = prev_nibble;
      pin_hold = (act.kind == KIND_INIT) ? INIT_WAIT_MS : CHAR_WAIT_MS;
    end else begin
      case (rel[1:0])
        2'd0: begin
          pin_en   = 1'b1;
          pin_nib  = byte_v[7:4];
          pin_hold = PULSE_MS;
        end
        2'd1: begin
          pin_nib  = byte_v[7:4];
          pin_hold = PULSE_MS;
        end
        2'd2: begin
          pin_en   = 1'b1;
          pin_hold = PULSE_MS;
        end
        default: begin
          pin_hold = TAIL_MS;
          nib_done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= SEQ_IDLE;
      step            <= 5'd0;
      out_valid       <= 1'b0;
      prev_reg_select <= 1'b0;
      prev_nibble     <= 4'd0;
    end else begin
      state <= state_next;
      if (go) begin
        step      <= is_last ? 5'd0 : s + 5'd1;
        out_valid <= 1'b1;
        if (nib_done) begin
          prev_reg_select <= pin_rs;
          prev_nibble     <= pin_nib & NIB_MASK;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (go) begin
      reg_select <= pin_rs;
      enable     <= pin_en;
      nibble     <= pin_nib;
      hold_ms    <= pin_hold;
      last       <= is_last;
    end
  end

  assign read_write = 1'b0;
  assign empty      = !out_valid;

endmodule

/* rtl/char_lcd_nibble_sequencer_top.sv */
// top level of the character lcd nibble sequencer
// instantiates lcds_front, lcds_queue and lcds_back; uses lcds_pkg
`timescale 1ns / 1ps

// usage
//   request side: drive req_type, row, column, char_code and raise push;
//   a request is taken at a clock edge where push is high and full is low
//   result side: while empty is low the oldest pin state sits on
//   reg_select, read_write, enable, nibble, hold_ms and last; raise pop to
//   take it, last marks the final pin state of a request
// first pin state
//   the first pin state of a request passes through the queue and then the
//   sequencer's result register, once the sequencer is free and its result register is empty or popped
// throughput
//   the back-end sequencer emits one pin state per cycle while pop keeps
//   its result register free; initialize and write character open with a
//   wait state, every request closes on a low-nibble tail state, and a
//   set cursor with a row other than 1 or 2 is taken and produces nothing
//   a QDEPTH-deep queue sits between front and back, so until it fills
//   requests keep being taken while the back works or the receiver stalls
// reset
//   rst empties the queue and result register and clears the remembered
//   rs and data levels to zero
// stall
//   with pop low the result holds; once the queue fills, full rises
module char_lcd_nibble_sequencer_top #(
  parameter int QDEPTH = lcds_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type,
  input  logic [1:0] row,
  input  logic [5:0] column,
  input  logic [7:0] char_code,
  output logic       empty,
  input  logic       pop,
  output logic       reg_select,
  output logic       read_write,
  output logic       enable,
  output logic [3:0] nibble,
  output logic [3:0] hold_ms,
  output logic       last
);
  import lcds_pkg::*;

  // classified request into the queue
  logic q_push;
  op_t  q_din;
  // queue head toward the sequencer
  op_t  q_head;
  logic q_empty;
  logic q_pop;

  lcds_front u_front (
    .push      (push),
    .req_type  (req_type),
    .row       (row),
    .column    (column),
    .char_code (char_code),
    .q_full    (full),
    .q_push    (q_push),
    .q_data    (q_din)
  );

  lcds_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  // sequencer with its own output register, stalls only while a result waits and pop is low
  lcds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .reg_select (reg_select),
    .read_write (read_write),
    .enable     (enable),
    .nibble     (nibble),
    .hold_ms    (hold_ms),
    .last       (last)
  );

endmodule

/* rtl/lcds_checker.sv */
// port-level checks for the character lcd nibble sequencer
// bound to char_lcd_nibble_sequencer_top; uses lcds_pkg constants
`timescale 1ns / 1ps

module lcds_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       reg_select,
  input logic       read_write,
  input logic       enable,
  input logic [3:0] nibble,
  input logic [3:0] hold_ms,
  input logic       last
);
  import lcds_pkg::*;

  // nothing waits on the result side after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(nibble) && $stable(enable)
                          && $stable(last) && $stable(hold_ms)
                          && $stable(reg_select)))
    else $error("stalled result changed");

  // bus is write only
  a_write_only: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !read_write)
    else $error("read_write driven high");

  // every enable pulse lasts the pulse width
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    (!empty && enable) |-> (hold_ms == PULSE_MS))
    else $error("enable pulse with wrong hold");

  // a request ends on the low-nibble tail state
  a_tail: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (!enable && hold_ms == TAIL_MS))
    else $error("final state is not the tail");

endmodule

bind char_lcd_nibble_sequencer_top lcds_checker u_lcds_checker (.*);

/* bench/char_lcd_nibble_sequencer_top_tb.sv */
// self-checking bench for the character lcd nibble sequencer top level
// drives random and directed requests, predicts the pin-state stream, checks each result
// depends on lcds_pkg and char_lcd_nibble_sequencer_top
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_top_tb;
  import lcds_pkg::*;

  // bench timing and run shape
  localparam int          RESET_CYCLES   = 5;
  localparam int          ITEM_TARGET    = 310;  // requests that produce pin states
  localparam int          IDLE_LIMIT     = 5000; // cycles with no handshake before giving up
  localparam int          LONG_HOLD      = 400;  // receiver hold-off used to fill the block
  localparam int unsigned LONG_HOLD_AT   = 300;  // pin states checked before the hold-off
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          REPORT_LIMIT   = 10;

  // expected pin timing, in ms
  localparam logic [3:0] T_INIT_WAIT = 4'd15;
  localparam logic [3:0] T_CHAR_WAIT = 4'd8;
  localparam logic [3:0] T_PULSE     = 4'd5;
  localparam logic [3:0] T_TAIL      = 4'd3;

  // instruction bytes
  localparam logic [7:0] BYTE_CLEAR     = 8'h01;
  localparam logic [7:0] BYTE_ROW1_BASE = 8'h80;
  localparam logic [7:0] BYTE_ROW2_BASE = 8'hC0;
  localparam logic [7:0] POWER_UP_BYTES [5] = '{8'h02, 8'h28, 8'h01, 8'h0C, 8'h06};

  // one request as it goes onto the bus
  typedef struct {
    req_code_t  kind;
    logic [1:0] row;
    logic [5:0] col;
    logic [7:0] chr;
  } lcd_req_t;

  // one timed pin state as the display would see it
  typedef struct {
    logic       rs;
    logic       rw;
    logic       en;
    logic [3:0] nib;
    logic [3:0] hold;
    logic       fin;
  } pin_state_t;

  // how the receiver paces its pops
  typedef enum logic [1:0] {
    POP_ALWAYS = 2'd0,
    POP_HALF   = 2'd1,
    POP_SPARSE = 2'd2,
    POP_TOGGLE = 2'd3
  } pop_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [1:0] req_type = '0;
  logic [1:0] row = '0;
  logic [5:0] column = '0;
  logic [7:0] char_code = '0;
  logic       full;
  logic       empty;
  logic       reg_select;
  logic       read_write;
  logic       enable;
  logic [3:0] nibble;
  logic [3:0] hold_ms;
  logic       last;

  char_lcd_nibble_sequencer_top uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .row        (row),
    .column     (column),
    .char_code  (char_code),
    .empty      (empty),
    .pop        (pop),
    .reg_select (reg_select),
    .read_write (read_write),
    .enable     (enable),
    .nibble     (nibble),
    .hold_ms    (hold_ms),
    .last       (last)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // requests waiting for the driver, pin states waiting for the monitor
  lcd_req_t   pending_reqs [$];
  pin_state_t pin_expect_q [$];

  // shadow of the levels the block last put on rs and d7..d4
  logic       shadow_rs  = 1'b0;
  logic [3:0] shadow_nib = 4'h0;

  int unsigned requests_planned = 0;
  int unsigned producing_planned = 0;
  int unsigned requests_taken = 0;
  int unsigned kind_taken [4] = '{0, 0, 0, 0};
  int unsigned pins_checked = 0;
  int unsigned bad_count = 0;
  int unsigned full_stall_cycles = 0;
  bit          draining = 1'b0;

  // ---------------------------------------------------------------------------
  // pin-state prediction
  // ---------------------------------------------------------------------------

  task automatic emit_pin(input logic rs, input logic en, input logic [3:0] nib,
                          input logic [3:0] hold);
    pin_state_t p;
    p.rs   = rs;
    p.rw   = 1'b0;  // bus is write-only
    p.en   = en;
    p.nib  = nib;
    p.hold = hold;
    p.fin  = 1'b0;
    pin_expect_q.push_back(p);
  endtask

  // one byte: high nibble then low, each with an enable pulse
  task automatic emit_byte(input logic rs, input logic [7:0] b);
    emit_pin(rs, 1'b1, b[7:4], T_PULSE);
    emit_pin(rs, 1'b0, b[7:4], T_PULSE);
    emit_pin(rs, 1'b1, b[3:0], T_PULSE);
    emit_pin(rs, 1'b0, b[3:0], T_TAIL);
    shadow_rs  = rs;
    shadow_nib = b[3:0];
  endtask

  // expand an accepted request into the pin states it should produce
  task automatic expand_request(input lcd_req_t r);
    int         queued_before;
    logic [7:0] addr;
    pin_state_t tail;
    queued_before = pin_expect_q.size();
    case (r.kind)
      REQ_INIT: begin
        // power-up wait keeps whatever levels were last driven
        emit_pin(shadow_rs, 1'b0, shadow_nib, T_INIT_WAIT);
        foreach (POWER_UP_BYTES[i]) emit_byte(1'b0, POWER_UP_BYTES[i]);
      end
      REQ_CLEAR: begin
        emit_byte(1'b0, BYTE_CLEAR);
      end
      REQ_CURSOR: begin
        // address is computed in 8 bits; column 0 lands one below the row base
        if (r.row == ROW_FIRST) begin
          addr = BYTE_ROW1_BASE + {2'b00, r.col} - 8'd1;
          emit_byte(1'b0, addr);
        end else if (r.row == ROW_SECOND) begin
          addr = BYTE_ROW2_BASE + {2'b00, r.col} - 8'd1;
          emit_byte(1'b0, addr);
        end
      end
      REQ_WRITE: begin
        emit_pin(shadow_rs, 1'b0, shadow_nib, T_CHAR_WAIT);
        emit_byte(1'b1, r.chr);
      end
    endcase
    // mark the closing pin state of this request
    if (pin_expect_q.size() > queued_before) begin
      tail = pin_expect_q.pop_back();
      tail.fin = 1'b1;
      pin_expect_q.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus planning
  // ---------------------------------------------------------------------------

  task automatic plan_req(input req_code_t kind, input logic [1:0] r, input logic [5:0] c,
                          input logic [7:0] ch);
    lcd_req_t q;
    q.kind = kind;
    q.row  = r;
    q.col  = c;
    q.chr  = ch;
    pending_reqs.push_back(q);
    requests_planned++;
    // cursor requests on a bad row are swallowed and do not count
    if (kind != REQ_CURSOR || r == ROW_FIRST || r == ROW_SECOND)
      producing_planned++;
  endtask

  // directed corners, then weighted random traffic
  initial begin
    req_code_t  k;
    logic [1:0] r;
    logic [5:0] c;
    int unsigned pick;

    // reset-state hold levels, both char extremes, clear
    plan_req(REQ_INIT,   2'd0, 6'd0,  8'h00);
    plan_req(REQ_WRITE,  2'd3, 6'd63, 8'h00);
    plan_req(REQ_WRITE,  2'd0, 6'd0,  8'hFF);
    plan_req(REQ_CLEAR,  2'd3, 6'd63, 8'hFF);
    // cursor at both ends of both lines
    plan_req(REQ_CURSOR, ROW_FIRST,  6'd1,  8'h00);
    plan_req(REQ_CURSOR, ROW_FIRST,  6'd40, 8'h00);
    plan_req(REQ_CURSOR, ROW_SECOND, 6'd1,  8'h00);
    plan_req(REQ_CURSOR, ROW_SECOND, 6'd40, 8'h00);
    // rows outside 1..2 emit nothing and leave the levels alone
    plan_req(REQ_CURSOR, 2'd0, 6'd5,  8'h00);
    plan_req(REQ_CURSOR, 2'd3, 6'd63, 8'hFF);
    // column zero lands below the row base, oversized columns run past column 40
    plan_req(REQ_CURSOR, ROW_FIRST,  6'd0,  8'h00);
    plan_req(REQ_CURSOR, ROW_SECOND, 6'd0,  8'h00);
    plan_req(REQ_CURSOR, ROW_SECOND, 6'd63, 8'h00);
    plan_req(REQ_CURSOR, ROW_FIRST,  6'd63, 8'h00);
    plan_req(REQ_WRITE,  2'd1, 6'd20, 8'hA5);
    plan_req(REQ_CURSOR, 2'd0, 6'd0,  8'h00);
    // init after a data write holds rs high and the last low nibble
    plan_req(REQ_INIT,   2'd2, 6'd42, 8'h3C);
    plan_req(REQ_WRITE,  2'd2, 6'd21, 8'h5A);
    plan_req(REQ_WRITE,  2'd1, 6'd10, 8'h80);
    plan_req(REQ_CLEAR,  2'd0, 6'd0,  8'h00);
    plan_req(REQ_WRITE,  2'd0, 6'd0,  8'h0F);
    plan_req(REQ_INIT,   2'd1, 6'd1,  8'hF0);
    plan_req(REQ_INIT,   2'd3, 6'd33, 8'hC3);

    // random mix; mostly cursor moves and writes, occasional inits
    while (producing_planned < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       k = REQ_INIT;
      else if (pick < 20) k = REQ_CLEAR;
      else if (pick < 58) k = REQ_CURSOR;
      else                k = REQ_WRITE;
      r = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(0, 3));
      c = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(1, 40)) : 6'($urandom_range(0, 63));
      plan_req(k, r, c, 8'($urandom_range(0, 255)));
    end
  end

  // single reset at the start
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // request driver: bursts of back-to-back requests with random gaps
  // ---------------------------------------------------------------------------

  lcd_req_t on_bus;
  int       burst_left = 1;
  int       gap_left = 0;

  function automatic int next_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 0;
    if (pick < 80) return $urandom_range(1, 4);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      push       <= 1'b0;
      burst_left  = $urandom_range(1, 16);
      gap_left    = 0;
    end else begin
      // request taken at this edge: predict it right away
      if (push && !full) begin
        expand_request(on_bus);
        kind_taken[on_bus.kind]++;
        requests_taken++;
      end
      if (push && full) begin
        // block is backed up, keep the same request on the bus
        full_stall_cycles++;
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        on_bus     = pending_reqs.pop_front();
        push      <= 1'b1;
        req_type  <= on_bus.kind;
        row       <= on_bus.row;
        column    <= on_bus.col;
        char_code <= on_bus.chr;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = next_gap();
        end else begin
          burst_left--;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // pin-state monitor and receiver pacing
  // ---------------------------------------------------------------------------

  pop_mode_t pop_mode = POP_ALWAYS;
  int        mode_left = 0;
  int        hold_left = 0;
  bit        long_hold_done = 1'b0;

  task automatic check_pin_state();
    pin_state_t want;
    if (pin_expect_q.size() == 0) begin
      bad_count++;
      if (bad_count <= REPORT_LIMIT)
        $display("%0t: unexpected pin state rs=%0b rw=%0b en=%0b nib=%h hold=%0d last=%0b",
                 $realtime, reg_select, read_write, enable, nibble, hold_ms, last);
    end else begin
      want = pin_expect_q.pop_front();
      if (reg_select !== want.rs || read_write !== want.rw || enable !== want.en ||
          nibble !== want.nib || hold_ms !== want.hold || last !== want.fin) begin
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
          $display("%0t: pin state %0d expected rs=%0b rw=%0b en=%0b nib=%h hold=%0d last=%0b, got rs=%0b rw=%0b en=%0b nib=%h hold=%0d last=%0b",
                   $realtime, pins_checked, want.rs, want.rw, want.en, want.nib, want.hold,
                   want.fin, reg_select, read_write, enable, nibble, hold_ms, last);
      end
      pins_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_pin_state();

      if (hold_left > 0) begin
        // long hold-off in progress, sender keeps offering
        hold_left--;
        pop <= 1'b0;
      end else if (!long_hold_done && pins_checked >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        pop           <= 1'b0;
      end else if (draining) begin
        // pull out anything stray at the end
        pop <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          pop_mode  = pop_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (pop_mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_HALF:   pop <= 1'($urandom_range(0, 1));
          POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
          POP_TOGGLE: pop <= ~pop;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any handshake on either side
  // ---------------------------------------------------------------------------

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a handshake, %0d pin states still expected",
                 idle_cycles, pin_expect_q.size());
        $display("char_lcd_nibble_sequencer_top_tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // end of run
  // ---------------------------------------------------------------------------

  initial begin
    @(negedge rst);
    // every request taken and every predicted pin state seen
    while (requests_taken != requests_planned || pin_expect_q.size() != 0)
      @(posedge clk);
    draining = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d requests (%0d init, %0d clear, %0d cursor, %0d write), %0d pin states checked",
             requests_taken, kind_taken[REQ_INIT], kind_taken[REQ_CLEAR],
             kind_taken[REQ_CURSOR], kind_taken[REQ_WRITE], pins_checked);
    $display("input held off by full for %0d cycles, %0d mismatches, %0d pin states outstanding",
             full_stall_cycles, bad_count, pin_expect_q.size());
    if (bad_count == 0 && pin_expect_q.size() == 0)
      $display("char_lcd_nibble_sequencer_top_tb passed");
    else
      $display("char_lcd_nibble_sequencer_top_tb failed");
    $finish;
  end

endmodule
